// ===== hdl/drps_pkg.sv =====
// ----------------------------------------------------------------------------
// drps_pkg
// Shared types, constants and helpers of the dirty rectangle present scheduler.
// ----------------------------------------------------------------------------
package drps_pkg;

	localparam int SCR_W = 320;
	localparam int SCR_H = 240;
	localparam int XW = 9;
	localparam int YW = 8;
	localparam int DIV_W = 48;
	localparam int DVS_W = 14;
	localparam int STEP_W = 6;

	localparam logic [13:0] TPS_RST = 14'd100;
	localparam logic [7:0] FPS_RST = 8'd30;

	localparam logic [1:0] CFG_TPS = 2'd0;
	localparam logic [1:0] CFG_FPS = 2'd1;

	localparam logic [1:0] SYNC_NONE = 2'd0;
	localparam logic [1:0] SYNC_BAD = 2'd3;

	typedef enum logic [2:0] {
		MODE_INIT = 3'd0,
		MODE_QUEUE = 3'd1,
		MODE_TICK = 3'd2,
		MODE_PRESENT = 3'd3,
		MODE_OWN = 3'd4,
		MODE_HOME = 3'd5
	} mode_t;

	typedef struct packed {
		logic [2:0] mode;
		logic signed [15:0] rect_x;
		logic signed [15:0] rect_y;
		logic signed [15:0] rect_width;
		logic signed [15:0] rect_height;
		logic [1:0] sync_kind;
		logic [31:0] now;
		logic home_active;
		logic submit_ok;
	} in_t;

	typedef struct packed {
		logic issued;
		logic [8:0] out_x1;
		logic [7:0] out_y1;
		logic [8:0] out_x2;
		logic [7:0] out_y2;
		logic [1:0] out_sync;
		logic out_full;
		logic still_pending;
		logic deferred_waiting;
		logic [31:0] present_count;
		logic deadline_missed;
		logic [31:0] overdue_ticks;
	} out_t;

	typedef struct packed {
		logic [XW-1:0] x1;
		logic [YW-1:0] y1;
		logic [XW-1:0] x2;
		logic [YW-1:0] y2;
	} rect_t;

	typedef struct packed {
		logic load;
		logic exec;
		logic qr_start;
		logic qr_latch;
		logic loop_step;
		logic prep;
		logic div1_start;
		logic calc_k;
		logic mul;
		logic div2_start;
		logic fin;
		logic emit;
	} cmd_t;

	typedef struct packed {
		logic need_sched;
		logic div_done;
		logic loop_more;
		logic loop_catch;
		logic q_zero;
		logic out_free;
	} stat_t;

	function automatic logic is_full(rect_t r);
		return r.x1 == '0 && r.y1 == '0 && r.x2 == XW'(SCR_W - 1) &&
			r.y2 == YW'(SCR_H - 1);
	endfunction

	function automatic rect_t merge_into(rect_t base, logic valid, rect_t r);
		rect_t u;
		u = r;
		if (valid) begin
			u.x1 = (r.x1 < base.x1) ? r.x1 : base.x1;
			u.y1 = (r.y1 < base.y1) ? r.y1 : base.y1;
			u.x2 = (r.x2 > base.x2) ? r.x2 : base.x2;
			u.y2 = (r.y2 > base.y2) ? r.y2 : base.y2;
		end
		return u;
	endfunction

endpackage

// ===== hdl/dirty_rect_present_scheduler_top.sv =====
// ----------------------------------------------------------------------------
// dirty_rect_present_scheduler_top
// Dirty rectangle present scheduler with a fractional frame clock.
// ----------------------------------------------------------------------------
// Channel  Direction  Handshake              Word
// in       input      in_valid / in_ready    in_data, one scheduler command
// out      output     out_valid / out_ready  out_data, one status result
// cfg      input      cfg_valid / cfg_ready  cfg_index, cfg_data
//
// Most words pass through accept, execute and result register load.
// A scheduled tick adds the interval divide and the frame clock steps, and
// on catch-up two divides (only the second when the interval quotient is
// zero). All divides use the shared restoring divider.
// Reset needs no clear pass.
// A new word is taken while a result waits; it executes at once and its
// result load then holds until out is free. Configuration writes are always ready.
// ----------------------------------------------------------------------------
module dirty_rect_present_scheduler_top (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	input drps_pkg::in_t in_data,
	output logic out_valid,
	input logic out_ready,
	output drps_pkg::out_t out_data,
	input logic cfg_valid,
	output logic cfg_ready,
	input logic [1:0] cfg_index,
	input logic [13:0] cfg_data
);
	import drps_pkg::*;

	cmd_t cmd;
	stat_t st;

	assign cfg_ready = 1'b1;

	drps_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.st(st),
		.cmd(cmd)
	);

	drps_dp u_dp (
		.clk(clk),
		.arst_n(arst_n),
		.in_data(in_data),
		.cfg_valid(cfg_valid),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.out_data(out_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.cmd(cmd),
		.st(st)
	);

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready)
		else $error("input accepted while a word is in execution");

	a_emit_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> st.out_free)
		else $error("result loaded over an untaken result");

	a_div_one: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.qr_start, cmd.div1_start, cmd.div2_start}))
		else $error("divider started twice in one cycle");

endmodule

// ===== hdl/drps_div.sv =====
// ----------------------------------------------------------------------------
// drps_div
// Restoring divider, one quotient bit per cycle, with a step count per run.
// ----------------------------------------------------------------------------
module drps_div (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic [drps_pkg::DIV_W-1:0] dividend,
	input logic [drps_pkg::DVS_W-1:0] divisor,
	input logic [drps_pkg::STEP_W-1:0] steps,
	output logic [drps_pkg::DIV_W-1:0] quot,
	output logic [drps_pkg::DVS_W-1:0] rem,
	output logic done
);
	import drps_pkg::*;

	logic [DIV_W-1:0] dvd_q;
	logic [DVS_W-1:0] rem_q;
	logic [DVS_W-1:0] dvs_q;
	logic [STEP_W-1:0] cnt_q;
	logic busy_q;
	logic done_q;
	logic [DVS_W+1:0] diff;
	logic ge;

	assign diff = {1'b0, rem_q, dvd_q[DIV_W-1]} - {2'b00, dvs_q};
	assign ge = !diff[DVS_W+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q <= steps;
		end else if (busy_q) begin
			cnt_q <= cnt_q - STEP_W'(1);
			if (cnt_q == STEP_W'(1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[DIV_W-2:0], ge};
			rem_q <= ge ? diff[DVS_W-1:0] : {rem_q[DVS_W-2:0], dvd_q[DIV_W-1]};
		end
	end

	assign quot = dvd_q;
	assign rem = rem_q;
	assign done = done_q;

endmodule

// ===== hdl/drps_ctrl.sv =====
// ----------------------------------------------------------------------------
// drps_ctrl
// Sequencer for execute, frame clock stepping and catch-up division.
// ----------------------------------------------------------------------------
module drps_ctrl (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	input drps_pkg::stat_t st,
	output drps_pkg::cmd_t cmd
);
	import drps_pkg::*;

	typedef enum logic [11:0] {
		S_IDLE = 12'b000000000001,
		S_EXEC = 12'b000000000010,
		S_QR_WAIT = 12'b000000000100,
		S_LOOP = 12'b000000001000,
		S_CU_PREP = 12'b000000010000,
		S_DIV1_WAIT = 12'b000000100000,
		S_CU_K = 12'b000001000000,
		S_CU_MUL = 12'b000010000000,
		S_CU_D2 = 12'b000100000000,
		S_DIV2_WAIT = 12'b001000000000,
		S_CU_FIN = 12'b010000000000,
		S_EMIT = 12'b100000000000
	} state_t;

	state_t state_q, state_d;

	assign in_ready = (state_q == S_IDLE);

	always_comb begin
		state_d = state_q;
		cmd = '0;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d = S_EXEC;
				end
			end
			S_EXEC: begin
				cmd.exec = 1'b1;
				if (st.need_sched) begin
					cmd.qr_start = 1'b1;
					state_d = S_QR_WAIT;
				end else begin
					state_d = S_EMIT;
				end
			end
			S_QR_WAIT: begin
				if (st.div_done) begin
					cmd.qr_latch = 1'b1;
					state_d = S_LOOP;
				end
			end
			S_LOOP: begin
				cmd.loop_step = 1'b1;
				if (!st.loop_more) begin
					state_d = st.loop_catch ? S_CU_PREP : S_EMIT;
				end
			end
			S_CU_PREP: begin
				cmd.prep = 1'b1;
				if (st.q_zero) begin
					state_d = S_CU_MUL;
				end else begin
					cmd.div1_start = 1'b1;
					state_d = S_DIV1_WAIT;
				end
			end
			S_DIV1_WAIT: begin
				if (st.div_done) begin
					state_d = S_CU_K;
				end
			end
			S_CU_K: begin
				cmd.calc_k = 1'b1;
				state_d = S_CU_MUL;
			end
			S_CU_MUL: begin
				cmd.mul = 1'b1;
				state_d = S_CU_D2;
			end
			S_CU_D2: begin
				cmd.div2_start = 1'b1;
				state_d = S_DIV2_WAIT;
			end
			S_DIV2_WAIT: begin
				if (st.div_done) begin
					state_d = S_CU_FIN;
				end
			end
			S_CU_FIN: begin
				cmd.fin = 1'b1;
				state_d = S_EMIT;
			end
			S_EMIT: begin
				if (st.out_free) begin
					cmd.emit = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

// ===== hdl/drps_dp.sv =====
// ----------------------------------------------------------------------------
// drps_dp
// Rectangle state, clipping and merging, frame clock and result register.
// ----------------------------------------------------------------------------
module drps_dp (
	input logic clk,
	input logic arst_n,
	input drps_pkg::in_t in_data,
	input logic cfg_valid,
	input logic [1:0] cfg_index,
	input logic [13:0] cfg_data,
	output drps_pkg::out_t out_data,
	output logic out_valid,
	input logic out_ready,
	input drps_pkg::cmd_t cmd,
	output drps_pkg::stat_t st
);
	import drps_pkg::*;

	localparam logic signed [17:0] W_S = 18'(SCR_W);
	localparam logic signed [17:0] H_S = 18'(SCR_H);

	in_t in_q;
	logic [13:0] tps_q;
	logic [7:0] fps_q;
	logic init_q, home_q, mp_q, sp_q;
	rect_t m_q, sr_q;
	logic [1:0] ms_q;
	logic [31:0] cnt_q, dl_q;
	logic [7:0] acc_q;

	logic a_iss_q, a_full_q, a_miss_q;
	rect_t a_rect_q;
	logic [1:0] a_sync_q;
	logic [31:0] a_late_q;

	logic [13:0] q_q;
	logic [7:0] r_q;
	logic [31:0] d_q;
	logic [39:0] k_q;
	logic [47:0] tot_q;
	logic [31:0] kq_q;

	out_t out_q;
	logic out_valid_q;

	logic nx_init, nx_home, nx_mp, nx_sp;
	rect_t nx_m, nx_sr;
	logic [1:0] nx_ms;
	logic [31:0] nx_cnt, nx_dl;
	logic [7:0] nx_acc;
	logic a_iss, a_full, a_miss;
	rect_t a_rect;
	logic [1:0] a_sync;
	logic [31:0] a_late;
	logic need_sched;

	logic [7:0] fps_eff;
	logic [8:0] lp_sum;
	logic lp_ge;
	logic [7:0] lp_acc;
	logic [14:0] lp_iv;
	logic [31:0] lp_dl, lp_d;

	logic [31:0] dp1;
	logic [39:0] num;
	logic div_start;
	logic [DIV_W-1:0] div_dvd, div_quot;
	logic [DVS_W-1:0] div_dvs, div_rem;
	logic [STEP_W-1:0] div_steps;
	logic div_done;

	assign fps_eff = (fps_q == '0) ? 8'd1 : fps_q;

	always_comb begin
		logic signed [17:0] x, y, w, h, x2, y2;
		logic vld, f, do_pres;
		logic [1:0] s;
		rect_t cr;
		logic [31:0] d;

		nx_init = init_q;
		nx_home = home_q;
		nx_mp = mp_q;
		nx_sp = sp_q;
		nx_m = m_q;
		nx_sr = sr_q;
		nx_ms = ms_q;
		nx_cnt = cnt_q;
		nx_dl = dl_q;
		nx_acc = acc_q;
		a_iss = 1'b0;
		a_full = 1'b0;
		a_miss = 1'b0;
		a_rect = '0;
		a_sync = SYNC_NONE;
		a_late = '0;
		need_sched = 1'b0;
		do_pres = 1'b0;
		f = 1'b0;

		s = (in_q.sync_kind == SYNC_BAD) ? SYNC_NONE : in_q.sync_kind;
		x = 18'(in_q.rect_x);
		y = 18'(in_q.rect_y);
		w = 18'(in_q.rect_width);
		h = 18'(in_q.rect_height);
		vld = (w > 18'sd0) && (h > 18'sd0);
		if (x < 18'sd0) begin
			w = w + x;
			x = '0;
		end
		if (y < 18'sd0) begin
			h = h + y;
			y = '0;
		end
		vld = vld && (x < W_S) && (y < H_S) && (w > 18'sd0) && (h > 18'sd0);
		if (x + w > W_S) begin
			w = W_S - x;
		end
		if (y + h > H_S) begin
			h = H_S - y;
		end
		x2 = x + w - 18'sd1;
		y2 = y + h - 18'sd1;
		cr.x1 = x[XW-1:0];
		cr.y1 = y[YW-1:0];
		cr.x2 = x2[XW-1:0];
		cr.y2 = y2[YW-1:0];
		d = in_q.now - dl_q;

		if ((in_q.mode == MODE_QUEUE || in_q.mode == MODE_OWN) && !init_q) begin
			nx_dl = in_q.now;
			nx_acc = '0;
			nx_init = 1'b1;
			nx_home = 1'b0;
			nx_mp = 1'b0;
			nx_ms = SYNC_NONE;
			nx_sp = 1'b0;
		end

		unique case (in_q.mode)
			MODE_INIT: begin
				nx_dl = in_q.now;
				nx_acc = '0;
				nx_init = 1'b1;
				nx_home = 1'b0;
				nx_mp = 1'b0;
				nx_ms = SYNC_NONE;
				nx_sp = 1'b0;
			end
			MODE_QUEUE: begin
				if (vld) begin
					if (is_full(cr)) begin
						if (nx_mp && nx_ms != SYNC_NONE) begin
							nx_sr = merge_into(nx_sr, nx_sp, cr);
							nx_sp = 1'b1;
						end else begin
							nx_m = cr;
							nx_ms = SYNC_NONE;
							nx_mp = 1'b1;
							nx_sp = 1'b0;
						end
					end else if (!nx_mp) begin
						nx_m = cr;
						nx_ms = s;
						nx_mp = 1'b1;
					end else if (is_full(nx_m)) begin
						if (s != SYNC_NONE) begin
							nx_sr = merge_into(nx_sr, nx_sp, nx_m);
							nx_sp = 1'b1;
							nx_m = cr;
							nx_ms = s;
						end
					end else if (s == SYNC_NONE && nx_ms != SYNC_NONE) begin
						nx_sr = merge_into(nx_sr, nx_sp, cr);
						nx_sp = 1'b1;
					end else if (s != SYNC_NONE && nx_ms == SYNC_NONE) begin
						nx_sr = merge_into(nx_sr, nx_sp, nx_m);
						nx_sp = 1'b1;
						nx_m = cr;
						nx_ms = s;
					end else begin
						if (s != SYNC_NONE) begin
							nx_ms = s;
						end
						nx_m = merge_into(nx_m, 1'b1, cr);
					end
				end
			end
			MODE_TICK: begin
				if (mp_q) begin
					f = is_full(m_q);
					if (home_q && ms_q == SYNC_NONE && !f) begin
						do_pres = 1'b0;
					end else if (f) begin
						do_pres = 1'b1;
						nx_dl = in_q.now;
						nx_acc = '0;
					end else if (!d[31]) begin
						a_miss = (d != '0);
						a_late = d;
						do_pres = 1'b1;
						need_sched = 1'b1;
					end
				end
			end
			MODE_PRESENT: begin
				do_pres = 1'b1;
			end
			MODE_OWN: begin
				nx_mp = 1'b0;
				nx_ms = SYNC_NONE;
				nx_sp = 1'b0;
			end
			MODE_HOME: begin
				nx_home = in_q.home_active;
			end
			default: begin
				do_pres = 1'b0;
			end
		endcase

		if (do_pres && nx_mp) begin
			f = is_full(nx_m);
			a_iss = 1'b1;
			a_rect = nx_m;
			a_full = f;
			a_sync = f ? SYNC_NONE : nx_ms;
			if (in_q.submit_ok) begin
				nx_mp = 1'b0;
				nx_ms = SYNC_NONE;
				nx_cnt = nx_cnt + 32'd1;
				if (nx_sp) begin
					nx_m = nx_sr;
					nx_mp = 1'b1;
					nx_sp = 1'b0;
				end
			end
		end
	end

	assign lp_sum = {1'b0, acc_q} + {1'b0, r_q};
	assign lp_ge = (lp_sum >= {1'b0, fps_eff});
	assign lp_acc = lp_ge ? 8'(lp_sum - {1'b0, fps_eff}) : lp_sum[7:0];
	always_comb begin
		lp_iv = {1'b0, q_q} + 15'(lp_ge);
		if (lp_iv == '0) begin
			lp_iv = 15'd1;
		end
	end
	assign lp_dl = dl_q + 32'(lp_iv);
	assign lp_d = in_q.now - lp_dl;

	assign dp1 = d_q + 32'd1;
	assign num = ({8'b0, dp1} * {32'b0, fps_eff}) - {32'b0, acc_q};

	always_comb begin
		div_start = cmd.qr_start | cmd.div1_start | cmd.div2_start;
		div_dvd = tot_q;
		div_dvs = {6'b0, fps_eff};
		div_steps = STEP_W'(DIV_W);
		if (cmd.qr_start) begin
			div_dvd = {tps_q, 34'b0};
			div_steps = STEP_W'(DVS_W);
		end else if (cmd.div1_start) begin
			div_dvd = {8'b0, num};
			div_dvs = tps_q;
		end
	end

	drps_div u_div (
		.clk(clk),
		.arst_n(arst_n),
		.start(div_start),
		.dividend(div_dvd),
		.divisor(div_dvs),
		.steps(div_steps),
		.quot(div_quot),
		.rem(div_rem),
		.done(div_done)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tps_q <= TPS_RST;
			fps_q <= FPS_RST;
			init_q <= 1'b0;
			home_q <= 1'b0;
			mp_q <= 1'b0;
			sp_q <= 1'b0;
			m_q <= '0;
			sr_q <= '0;
			ms_q <= SYNC_NONE;
			cnt_q <= '0;
			dl_q <= '0;
			acc_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid) begin
				if (cfg_index == CFG_TPS) begin
					tps_q <= cfg_data;
				end else if (cfg_index == CFG_FPS) begin
					fps_q <= cfg_data[7:0];
				end
			end
			if (cmd.exec) begin
				init_q <= nx_init;
				home_q <= nx_home;
				mp_q <= nx_mp;
				sp_q <= nx_sp;
				m_q <= nx_m;
				sr_q <= nx_sr;
				ms_q <= nx_ms;
				cnt_q <= nx_cnt;
				dl_q <= nx_dl;
				acc_q <= nx_acc;
			end
			if (cmd.loop_step) begin
				dl_q <= lp_dl;
				acc_q <= lp_acc;
			end
			if (cmd.fin) begin
				acc_q <= div_rem[7:0];
				if (q_q == '0) begin
					dl_q <= dl_q + k_q[31:0];
				end else begin
					dl_q <= dl_q + kq_q + div_quot[31:0];
				end
			end
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			in_q <= in_data;
		end
		if (cmd.exec) begin
			a_iss_q <= a_iss;
			a_full_q <= a_full;
			a_miss_q <= a_miss;
			a_rect_q <= a_rect;
			a_sync_q <= a_sync;
			a_late_q <= a_late;
		end
		if (cmd.qr_latch) begin
			q_q <= div_quot[13:0];
			r_q <= div_rem[7:0];
		end
		if (cmd.loop_step) begin
			d_q <= lp_d;
		end
		if (cmd.prep) begin
			k_q <= {8'b0, dp1};
		end
		if (cmd.calc_k) begin
			k_q <= div_quot[39:0] + 40'(div_rem != '0);
		end
		if (cmd.mul) begin
			tot_q <= {40'b0, acc_q} + ({8'b0, k_q} * {40'b0, r_q});
			kq_q <= k_q[31:0] * {18'b0, q_q};
		end
		if (cmd.emit) begin
			out_q.issued <= a_iss_q;
			out_q.out_x1 <= a_rect_q.x1;
			out_q.out_y1 <= a_rect_q.y1;
			out_q.out_x2 <= a_rect_q.x2;
			out_q.out_y2 <= a_rect_q.y2;
			out_q.out_sync <= a_sync_q;
			out_q.out_full <= a_full_q;
			out_q.still_pending <= mp_q;
			out_q.deferred_waiting <= sp_q;
			out_q.present_count <= cnt_q;
			out_q.deadline_missed <= a_miss_q;
			out_q.overdue_ticks <= a_late_q;
		end
	end

	assign out_data = out_q;
	assign out_valid = out_valid_q;

	assign st.need_sched = need_sched;
	assign st.div_done = div_done;
	assign st.loop_more = !lp_d[31] && (lp_acc >= fps_eff);
	assign st.loop_catch = !lp_d[31];
	assign st.q_zero = (q_q == '0);
	assign st.out_free = !out_valid_q || out_ready;

endmodule

// ===== tb/sv/dirty_rect_present_scheduler_top_test.sv =====
// ----------------------------------------------------------------------------
// dirty_rect_present_scheduler_top_test
// Self-checking testbench of the dirty rectangle present scheduler. A directed
// opening and constrained-by-hand random words run through several frame
// clock settings; every status word is checked against a predictor of the
// rectangle bookkeeping and the fractional frame clock.
// ----------------------------------------------------------------------------
module dirty_rect_present_scheduler_top_test;
	timeunit 1ns;
	timeprecision 1ps;

	import drps_pkg::*;

	localparam logic [2:0] MODE_SPARE_A = 3'd6;
	localparam logic [2:0] MODE_SPARE_B = 3'd7;
	localparam logic [1:0] SYNC_HOME = 2'd1;
	localparam logic [1:0] SYNC_MUSIC = 2'd2;
	localparam int CYCLE_LIMIT = 1500000;
	localparam int DRAIN_CYCLES = 200;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid;
	logic in_ready;
	in_t in_data;
	logic out_valid;
	logic out_ready;
	out_t out_data;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [1:0] cfg_index = '0;
	logic [13:0] cfg_data = '0;

	dirty_rect_present_scheduler_top uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data(out_data),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #6 clk = ~clk;

	// Scheduler state as the predictor sees it.
	int unsigned rate_tps = 100;
	int unsigned rate_fps = 30;
	bit sch_init, sch_home, main_pend, side_pend;
	int main_l, main_t, main_r, main_b;
	logic [1:0] main_sync;
	int side_l, side_t, side_r, side_b;
	int unsigned present_total, deadline, frac_accum;

	in_t pending_words[$];
	out_t expected_status[$];
	int unsigned now_cursor;
	int words_sent, results_checked, mismatches, settings_used;
	int burst_left, gap_left;
	longint cycles;

	function automatic bit rect_full(int x1, int y1, int x2, int y2);
		return x1 == 0 && y1 == 0 && x2 == SCR_W - 1 && y2 == SCR_H - 1;
	endfunction

	function automatic int tick_diff(int unsigned a, int unsigned b);
		return int'(a - b);
	endfunction

	function automatic void clock_restart(int unsigned now);
		deadline = now;
		frac_accum = 0;
		sch_init = 1'b1;
		sch_home = 1'b0;
		main_pend = 1'b0;
		main_sync = SYNC_NONE;
		side_pend = 1'b0;
	endfunction

	function automatic void load_main(int x1, int y1, int x2, int y2, logic [1:0] s);
		main_l = x1;
		main_t = y1;
		main_r = x2;
		main_b = y2;
		main_sync = s;
		main_pend = 1'b1;
	endfunction

	function automatic void defer_rect(int x1, int y1, int x2, int y2);
		if (!side_pend) begin
			side_l = x1;
			side_t = y1;
			side_r = x2;
			side_b = y2;
			side_pend = 1'b1;
		end else begin
			if (x1 < side_l) side_l = x1;
			if (y1 < side_t) side_t = y1;
			if (x2 > side_r) side_r = x2;
			if (y2 > side_b) side_b = y2;
		end
	endfunction

	function automatic void add_dirt(int x, int y, int w, int h, logic [1:0] s,
			int unsigned now);
		int x2, y2;
		if (!sch_init) clock_restart(now);
		if (w <= 0 || h <= 0) return;
		if (x < 0) begin
			w += x;
			x = 0;
		end
		if (y < 0) begin
			h += y;
			y = 0;
		end
		if (x >= SCR_W || y >= SCR_H || w <= 0 || h <= 0) return;
		if (x + w > SCR_W) w = SCR_W - x;
		if (y + h > SCR_H) h = SCR_H - y;
		x2 = x + w - 1;
		y2 = y + h - 1;
		if (rect_full(x, y, x2, y2)) begin
			if (main_pend && main_sync != SYNC_NONE) begin
				defer_rect(x, y, x2, y2);
				return;
			end
			load_main(x, y, x2, y2, SYNC_NONE);
			side_pend = 1'b0;
			return;
		end
		if (!main_pend) begin
			load_main(x, y, x2, y2, s);
			return;
		end
		if (rect_full(main_l, main_t, main_r, main_b)) begin
			if (s != SYNC_NONE) begin
				defer_rect(main_l, main_t, main_r, main_b);
				load_main(x, y, x2, y2, s);
			end
			return;
		end
		if (s == SYNC_NONE && main_sync != SYNC_NONE) begin
			defer_rect(x, y, x2, y2);
			return;
		end
		if (s != SYNC_NONE && main_sync == SYNC_NONE) begin
			defer_rect(main_l, main_t, main_r, main_b);
			load_main(x, y, x2, y2, s);
			return;
		end
		if (s != SYNC_NONE) main_sync = s;
		if (x < main_l) main_l = x;
		if (y < main_t) main_t = y;
		if (x2 > main_r) main_r = x2;
		if (y2 > main_b) main_b = y2;
	endfunction

	function automatic void attempt_present(bit ok, inout out_t o);
		bit full;
		if (!main_pend) return;
		full = rect_full(main_l, main_t, main_r, main_b);
		o.issued = 1'b1;
		o.out_x1 = main_l[8:0];
		o.out_y1 = main_t[7:0];
		o.out_x2 = main_r[8:0];
		o.out_y2 = main_b[7:0];
		o.out_full = full;
		o.out_sync = full ? SYNC_NONE : main_sync;
		if (!ok) return;
		main_pend = 1'b0;
		main_sync = SYNC_NONE;
		present_total++;
		if (side_pend) begin
			load_main(side_l, side_t, side_r, side_b, SYNC_NONE);
			side_pend = 1'b0;
		end
	endfunction

	function automatic void advance_deadline(int unsigned now);
		int unsigned fps, q, r, iv;
		int d;
		longint unsigned e0, num, hz, k, tot, adv;
		fps = (rate_fps != 0) ? rate_fps : 1;
		q = rate_tps / fps;
		r = rate_tps % fps;
		do begin
			iv = q;
			frac_accum += r;
			if (frac_accum >= fps) begin
				iv++;
				frac_accum -= fps;
			end
			if (iv < 1) iv = 1;
			deadline += iv;
			d = tick_diff(now, deadline);
		end while (d >= 0 && frac_accum >= fps);
		if (d < 0) return;
		if (q == 0) begin
			k = longint'(d) + 1;
			deadline += k[31:0];
			frac_accum = int'((longint'(frac_accum) + k * r) % fps);
		end else begin
			e0 = frac_accum;
			num = (longint'(d) + 1) * fps - e0;
			hz = longint'(q) * fps + r;
			k = (num + hz - 1) / hz;
			tot = e0 + k * r;
			adv = k * q + tot / fps;
			deadline += adv[31:0];
			frac_accum = int'(tot % fps);
		end
	endfunction

	function automatic out_t predict_status(in_t w);
		out_t o;
		logic [1:0] s;
		bit full;
		int d;
		o = '0;
		s = (w.sync_kind == SYNC_BAD) ? SYNC_NONE : w.sync_kind;
		case (w.mode)
			MODE_INIT: clock_restart(w.now);
			MODE_QUEUE: add_dirt(int'(w.rect_x), int'(w.rect_y), int'(w.rect_width),
				int'(w.rect_height), s, w.now);
			MODE_TICK: begin
				if (main_pend) begin
					full = rect_full(main_l, main_t, main_r, main_b);
					if (!(sch_home && main_sync == SYNC_NONE && !full)) begin
						if (full) begin
							attempt_present(w.submit_ok, o);
							deadline = w.now;
							frac_accum = 0;
						end else begin
							d = tick_diff(w.now, deadline);
							if (d >= 0) begin
								if (d > 0) begin
									o.deadline_missed = 1'b1;
									o.overdue_ticks = w.now - deadline;
								end
								attempt_present(w.submit_ok, o);
								advance_deadline(w.now);
							end
						end
					end
				end
			end
			MODE_PRESENT: attempt_present(w.submit_ok, o);
			MODE_OWN: begin
				if (!sch_init) clock_restart(w.now);
				main_pend = 1'b0;
				main_sync = SYNC_NONE;
				side_pend = 1'b0;
			end
			MODE_HOME: sch_home = w.home_active;
			default: ;
		endcase
		o.still_pending = main_pend;
		o.deferred_waiting = side_pend;
		o.present_count = present_total;
		return o;
	endfunction

	function automatic in_t make_word(logic [2:0] m, int x, int y, int w, int h,
			logic [1:0] s, int unsigned now, bit home, bit ok);
		in_t v;
		v.mode = m;
		v.rect_x = 16'(x);
		v.rect_y = 16'(y);
		v.rect_width = 16'(w);
		v.rect_height = 16'(h);
		v.sync_kind = s;
		v.now = now;
		v.home_active = home;
		v.submit_ok = ok;
		return v;
	endfunction

	function automatic in_t random_word();
		in_t v;
		int pick, span;
		pick = $urandom_range(0, 99);
		span = rate_tps / ((rate_fps != 0) ? rate_fps : 1) + 2;
		case ($urandom_range(0, 19))
			0: now_cursor = $urandom;
			1: now_cursor -= $urandom_range(0, 50);
			2: now_cursor += $urandom_range(0, span * 40);
			default: now_cursor += $urandom_range(0, span * 2);
		endcase
		v = make_word(MODE_QUEUE, int'($urandom_range(0, 420)) - 50,
			int'($urandom_range(0, 300)) - 40, int'($urandom_range(0, 200)) - 5,
			int'($urandom_range(0, 160)) - 5, 2'($urandom_range(0, 3)), now_cursor,
			$urandom_range(0, 1), $urandom_range(0, 9) != 0);
		case ($urandom_range(0, 9))
			0: begin
				v.rect_x = 16'($urandom);
				v.rect_y = 16'($urandom);
				v.rect_width = 16'($urandom);
				v.rect_height = 16'($urandom);
			end
			1: begin
				v.rect_x = 16'(-int'($urandom_range(0, 3)));
				v.rect_y = 16'(-int'($urandom_range(0, 3)));
				v.rect_width = 16'(SCR_W + $urandom_range(0, 8));
				v.rect_height = 16'(SCR_H + $urandom_range(0, 8));
			end
			default: ;
		endcase
		if (pick < 38) v.mode = MODE_QUEUE;
		else if (pick < 76) v.mode = MODE_TICK;
		else if (pick < 84) v.mode = MODE_PRESENT;
		else if (pick < 92) v.mode = MODE_HOME;
		else if (pick < 95) v.mode = MODE_OWN;
		else if (pick < 97) v.mode = MODE_INIT;
		else v.mode = $urandom_range(0, 1) ? MODE_SPARE_A : MODE_SPARE_B;
		return v;
	endfunction

	// Sender: bursts of random length separated by random gaps.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			in_data <= '0;
			burst_left = 1;
			gap_left = 0;
		end else begin
			if (in_valid && in_ready) begin
				expected_status.push_back(predict_status(in_data));
				words_sent++;
			end
			if (in_valid && !in_ready) begin
			end else if (gap_left > 0) begin
				gap_left--;
				in_valid <= 1'b0;
			end else if (pending_words.size() > 0) begin
				in_valid <= 1'b1;
				in_data <= pending_words.pop_front();
				burst_left--;
				if (burst_left <= 0) begin
					burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(50, 200) :
						$urandom_range(1, 12);
					gap_left = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 25);
				end
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Receiver: a random stall style, re-picked periodically, plus one long hold.
	int rx_cycle, rx_style, hold_left;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
			rx_cycle = 0;
			rx_style = 0;
			hold_left = 0;
		end else begin
			rx_cycle++;
			if (rx_cycle % 64 == 0) rx_style = $urandom_range(0, 3);
			if (rx_cycle == 1500) hold_left = 600;
			if (hold_left > 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else begin
				case (rx_style)
					0: out_ready <= 1'b1;
					1: out_ready <= $urandom_range(0, 3) != 0;
					2: out_ready <= $urandom_range(0, 3) == 0;
					default: out_ready <= rx_cycle[3];
				endcase
			end
		end
	end

	function automatic void field_check(string name, logic [31:0] e, logic [31:0] a);
		if (e !== a && mismatches <= 10)
			$display("status %0d: %s expected %0h got %0h", results_checked, name, e, a);
	endfunction

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (expected_status.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("status word with nothing expected: %0h", out_data);
			end else begin
				out_t e;
				e = expected_status.pop_front();
				if (e !== out_data) begin
					mismatches++;
					field_check("issued", e.issued, out_data.issued);
					field_check("out_x1", e.out_x1, out_data.out_x1);
					field_check("out_y1", e.out_y1, out_data.out_y1);
					field_check("out_x2", e.out_x2, out_data.out_x2);
					field_check("out_y2", e.out_y2, out_data.out_y2);
					field_check("out_sync", e.out_sync, out_data.out_sync);
					field_check("out_full", e.out_full, out_data.out_full);
					field_check("still_pending", e.still_pending, out_data.still_pending);
					field_check("deferred_waiting", e.deferred_waiting,
						out_data.deferred_waiting);
					field_check("present_count", e.present_count, out_data.present_count);
					field_check("deadline_missed", e.deadline_missed,
						out_data.deadline_missed);
					field_check("overdue_ticks", e.overdue_ticks, out_data.overdue_ticks);
				end
			end
			results_checked++;
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles == CYCLE_LIMIT) begin
			$display("timeout with %0d status words outstanding", expected_status.size());
			$display("*** FAILED ***");
			$finish;
		end
	end

	task automatic wait_idle();
		while (pending_words.size() > 0 || in_valid || expected_status.size() > 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(logic [1:0] idx, logic [13:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		if (idx == CFG_TPS) rate_tps = val;
		else rate_fps = val[7:0];
	endtask

	task automatic run_phase(int unsigned tps, int unsigned fps, int count);
		wait_idle();
		write_reg(CFG_TPS, 14'(tps));
		write_reg(CFG_FPS, 14'(fps));
		cfg_valid <= 1'b0;
		settings_used++;
		repeat (count) pending_words.push_back(random_word());
	endtask

	initial begin
		repeat (4) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;
		@(posedge clk);
		pending_words.push_back(make_word(MODE_TICK, 0, 0, 0, 0, SYNC_NONE, 5, 0, 1));
		pending_words.push_back(make_word(MODE_HOME, 0, 0, 0, 0, SYNC_NONE, 0, 1, 1));
		pending_words.push_back(make_word(MODE_QUEUE, 10, 20, 30, 40, SYNC_NONE, 100, 0, 1));
		pending_words.push_back(make_word(MODE_TICK, 0, 0, 0, 0, SYNC_NONE, 99, 0, 1));
		pending_words.push_back(make_word(MODE_TICK, 0, 0, 0, 0, SYNC_NONE, 100, 0, 1));
		pending_words.push_back(make_word(MODE_QUEUE, -5, -5, 400, 400, SYNC_BAD, 101, 0, 1));
		pending_words.push_back(make_word(MODE_PRESENT, 0, 0, 0, 0, SYNC_NONE, 101, 0, 0));
		pending_words.push_back(make_word(MODE_QUEUE, 50, 60, 10, 10, SYNC_HOME, 102, 0, 1));
		pending_words.push_back(make_word(MODE_HOME, 0, 0, 0, 0, SYNC_NONE, 103, 1, 1));
		pending_words.push_back(make_word(MODE_TICK, 0, 0, 0, 0, SYNC_NONE, 200, 0, 1));
		pending_words.push_back(make_word(MODE_QUEUE, 0, 0, 5, 5, SYNC_NONE, 201, 0, 1));
		pending_words.push_back(make_word(MODE_TICK, 0, 0, 0, 0, SYNC_NONE, 300, 0, 1));
		pending_words.push_back(make_word(MODE_QUEUE, 32767, 32767, 32767, 32767, SYNC_MUSIC,
			301, 0, 1));
		pending_words.push_back(make_word(MODE_QUEUE, 5, 5, 0, 9, SYNC_NONE, 302, 0, 1));
		pending_words.push_back(make_word(MODE_QUEUE, -32768, -32768, 32767, -32768,
			SYNC_NONE, 303, 0, 1));
		pending_words.push_back(make_word(MODE_QUEUE, 300, 230, 100, 100, SYNC_BAD, 304, 1, 1));
		pending_words.push_back(make_word(MODE_TICK, 0, 0, 0, 0, SYNC_NONE, 400, 0, 1));
		pending_words.push_back(make_word(MODE_HOME, 0, 0, 0, 0, SYNC_NONE, 401, 0, 1));
		pending_words.push_back(make_word(MODE_TICK, 0, 0, 0, 0, SYNC_NONE, 32'hFFFF_FFF0, 0, 1));
		pending_words.push_back(make_word(MODE_TICK, 0, 0, 0, 0, SYNC_NONE, 100000, 0, 1));
		pending_words.push_back(make_word(MODE_QUEUE, 1, 1, 2, 2, SYNC_MUSIC, 100001, 0, 1));
		pending_words.push_back(make_word(MODE_OWN, 0, 0, 0, 0, SYNC_NONE, 100002, 0, 1));
		pending_words.push_back(make_word(MODE_SPARE_A, 0, 0, 0, 0, SYNC_NONE, 0, 0, 0));
		pending_words.push_back(make_word(MODE_SPARE_B, -1, -1, -1, -1, SYNC_BAD,
			32'hFFFF_FFFF, 1, 1));
		pending_words.push_back(make_word(MODE_INIT, 0, 0, 0, 0, SYNC_NONE, 0, 0, 1));
		now_cursor = 0;
		repeat (200) pending_words.push_back(random_word());
		run_phase(16383, 255, 140);
		run_phase(97, 7, 140);
		run_phase(1, 255, 140);
		run_phase(10000, 1, 140);
		run_phase(7, 0, 130);
		run_phase(100, 30, 140);
		wait_idle();
		$display("Sent %0d command words and checked %0d status words over %0d rate settings.",
			words_sent, results_checked, settings_used + 1);
		$display("The run included a long receiver hold and %0d mismatching words.", mismatches);
		if (mismatches == 0 && expected_status.size() == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule
